// ===== hw/rtl/swrm_pkg.sv =====
`timescale 1ns / 1ps

package swrm_pkg;

   localparam int DATA_W      = 32;
   localparam int RATE_W      = 31;
   localparam int REQ_TDATA_W = 96;
   localparam int RSP_TDATA_W = 64;
   localparam int DIV_STEP_W  = 5;

   typedef logic [DATA_W-1:0] word_type;

   typedef struct packed {
      word_type allowance;
      word_type mean_rate;
   } rsp_beat_type;

endpackage

// ===== hw/rtl/sliding_window_rate_meter.sv =====
`timescale 1ns / 1ps

// Sliding-window byte rate meter. A request beat with req_tuser = 0 records
// xfer_bytes for now_second into a circular bucket memory of WINDOW+1 entries
// (one bucket per second seen, newest first); req_tuser = 1 asks for the
// transfer allowance, target_rate minus the newest bucket's bytes, clamped to
// max_transfer. Every request gives exactly one response beat carrying the
// stored average and the allowance. One item is in flight at a time. A
// query registers its allowance at acceptance; ST_DONE then loads the
// response register. A record runs ST_SETUP, then ST_READ and ST_CHECK per
// bucket (one memory read each) from the oldest to the one holding the
// current second; up to WINDOW older buckets are summed and, if any,
// divided by their count in ST_DIV, a radix-2 divider doing one quotient
// bit per cycle, else the average is zero. The next request beat can be
// taken once the response register is loaded; a stalled response
// holds a finished item until that register is free. The user must write
// target_rate via csr_wr_en/csr_wr_data while idle; nothing enforces it.
module sliding_window_rate_meter #(
   parameter int WINDOW = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [swrm_pkg::RATE_W-1:0]       csr_wr_data,   // target_rate
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [31:0] now_second, [63:32] xfer_bytes, [94:64] max_transfer, [95] zero
   input  logic [swrm_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                              req_tuser,     // [0] op
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] mean_rate, [63:32] allowance
   output logic [swrm_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int DEPTH = WINDOW + 1;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW    = $clog2(DEPTH + 1);
   localparam int SW    = PW + 2;
   localparam int RW    = FW + 1;
   localparam int EW    = 2 * swrm_pkg::DATA_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   localparam logic OP_RECORD = 1'b0;

   logic [EW-1:0] bucket_mem [DEPTH];

   logic [2:0]                          state_ff, state_in;
   logic [swrm_pkg::RATE_W-1:0]         target_ff;
   logic [PW-1:0]                       head_ff, head_in;
   logic [FW-1:0]                       fill_ff, fill_in;
   swrm_pkg::word_type                  newest_sec_ff, newest_sec_in;
   swrm_pkg::word_type                  newest_bytes_ff, newest_bytes_in;
   swrm_pkg::word_type                  now_ff, now_in;
   swrm_pkg::word_type                  avg_ff, avg_in;
   swrm_pkg::word_type                  allow_ff, allow_in;
   swrm_pkg::word_type                  total_ff, total_in;
   logic [FW-1:0]                       cnt_ff, cnt_in;
   logic [PW-1:0]                       ptr_ff, ptr_in;
   logic [FW-1:0]                       rem_ff, rem_in;
   logic [swrm_pkg::DIV_STEP_W-1:0]     step_ff, step_in;
   logic [EW-1:0]                       rd_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   swrm_pkg::rsp_beat_type              rsp_ff, rsp_in;

   swrm_pkg::word_type                  req_now, req_bytes;
   logic [swrm_pkg::RATE_W-1:0]         req_max;
   logic                                accept, hit;
   logic [PW-1:0]                       head_next, ptr_next;
   logic                                mem_we;
   logic [PW-1:0]                       mem_waddr;
   logic [EW-1:0]                       mem_wdata;
   logic [SW-1:0]                       oldest_raw;
   logic [PW-1:0]                       oldest;
   swrm_pkg::word_type                  target_w, max_w, allow_raw;
   logic [RW-1:0]                       div_shift;
   swrm_pkg::word_type                  rd_sec, rd_bytes;

   assign req_now   = req_tdata[31:0];
   assign req_bytes = req_tdata[63:32];
   assign req_max   = req_tdata[94:64];
   assign rd_sec    = rd_ff[EW-1:swrm_pkg::DATA_W];
   assign rd_bytes  = rd_ff[swrm_pkg::DATA_W-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   assign hit       = (fill_ff != '0) && (newest_sec_ff == req_now);
   assign head_next = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign ptr_next  = (ptr_ff == PW'(DEPTH - 1)) ? '0 : ptr_ff + 1'b1;

   assign mem_we    = accept && (req_tuser == OP_RECORD);
   assign mem_waddr = hit ? head_ff : head_next;
   assign mem_wdata = hit ? {req_now, newest_bytes_ff + req_bytes} : {req_now, req_bytes};

   assign oldest_raw = SW'(head_ff) + SW'(DEPTH) + SW'(1) - SW'(fill_ff);
   assign oldest     = (oldest_raw >= SW'(DEPTH)) ? PW'(oldest_raw - SW'(DEPTH))
                                                  : PW'(oldest_raw);

   assign target_w  = {1'b0, target_ff};
   assign max_w     = {1'b0, req_max};
   assign allow_raw = (fill_ff != '0 && newest_bytes_ff < target_w)
                      ? target_w - newest_bytes_ff : '0;

   assign div_shift = {rem_ff, total_ff[swrm_pkg::DATA_W-1]};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bucket_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= bucket_mem[ptr_ff];
   end

   always_comb begin
      state_in        = state_ff;
      head_in         = head_ff;
      fill_in         = fill_ff;
      newest_sec_in   = newest_sec_ff;
      newest_bytes_in = newest_bytes_ff;
      now_in          = now_ff;
      avg_in          = avg_ff;
      allow_in        = allow_ff;
      total_in        = total_ff;
      cnt_in          = cnt_ff;
      ptr_in          = ptr_ff;
      rem_in          = rem_ff;
      step_in         = step_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_in          = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == OP_RECORD) begin
                  now_in        = req_now;
                  allow_in      = '0;
                  newest_sec_in = req_now;
                  if (hit) begin
                     newest_bytes_in = newest_bytes_ff + req_bytes;
                  end else begin
                     newest_bytes_in = req_bytes;
                     head_in         = head_next;
                     if (fill_ff != FW'(DEPTH)) begin
                        fill_in = fill_ff + 1'b1;
                     end
                  end
                  state_in = ST_SETUP;
               end else begin
                  allow_in = (allow_raw > max_w) ? max_w : allow_raw;
                  state_in = ST_DONE;
               end
            end
         end
         ST_SETUP: begin
            ptr_in   = oldest;
            total_in = '0;
            cnt_in   = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (rd_sec == now_ff) begin
               rem_in  = '0;
               step_in = '0;
               if (cnt_ff == '0) begin
                  avg_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DIV;
               end
            end else begin
               total_in = total_ff + rd_bytes;
               cnt_in   = cnt_ff + 1'b1;
               ptr_in   = ptr_next;
               state_in = ST_READ;
            end
         end
         ST_DIV: begin
            if (div_shift >= RW'(cnt_ff)) begin
               rem_in   = FW'(div_shift - RW'(cnt_ff));
               total_in = {total_ff[swrm_pkg::DATA_W-2:0], 1'b1};
            end else begin
               rem_in   = FW'(div_shift);
               total_in = {total_ff[swrm_pkg::DATA_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == '1) begin
               avg_in   = total_in;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in     = 1'b1;
               rsp_in.mean_rate = avg_ff;
               rsp_in.allowance = allow_ff;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         target_ff    <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         avg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         avg_ff       <= avg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            target_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      newest_sec_ff   <= newest_sec_in;
      newest_bytes_ff <= newest_bytes_in;
      now_ff          <= now_in;
      allow_ff        <= allow_in;
      total_ff        <= total_in;
      cnt_ff          <= cnt_in;
      ptr_ff          <= ptr_in;
      rem_ff          <= rem_in;
      step_ff         <= step_in;
      rsp_ff          <= rsp_in;
   end

endmodule

// ===== hw/rtl/swrm_checker.sv =====
`timescale 1ns / 1ps

module swrm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [swrm_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   // one item in flight: a request beat closes the request side next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while an item is in flight");

   // a query passes through ST_DONE before its response is loaded, so no response in the cycle after acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response appeared without processing time");

   // allowance is clamped to a 31-bit max_transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[swrm_pkg::RSP_TDATA_W-1])
      else $error("allowance exceeds 31 bits");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response beat changed");

endmodule

bind sliding_window_rate_meter swrm_checker u_swrm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
